// ===== design/bba_pkg.sv =====
// Shared types, constants and helper functions of the buddy block allocator.
`default_nettype none

package bba_pkg;

    localparam int MAX_ORDER = 6;
    localparam int ROW_DEPTH = 64;
    localparam int ADDR_W    = $clog2(ROW_DEPTH);
    localparam int CNT_W     = $clog2(ROW_DEPTH + 1);
    localparam int ORDER_W   = 3;
    localparam int OWNER_W   = 16;
    localparam int SIZE_W    = 7;

    localparam logic CMD_ALLOC       = 1'b0;
    localparam logic CMD_LIST        = 1'b1;
    localparam logic KIND_ALLOC      = 1'b0;
    localparam logic KIND_BLOCK      = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [OWNER_W-1:0] owner_id;
        logic [SIZE_W-1:0]  request_size;
    } req_item_t;

    typedef struct packed {
        logic               result_kind;
        logic               status;
        logic [CNT_W-1:0]   block_count;
        logic [OWNER_W-1:0] block_owner;
        logic [ORDER_W-1:0] block_order;
        logic               last;
    } rsp_item_t;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [OWNER_W-1:0] owner;
    } row_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        row_entry_t        data;
    } row_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } row_rd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_SPLIT_LO,
        ST_SPLIT_HI,
        ST_REPORT,
        ST_LIST_RD,
        ST_LIST_LD
    } state_t;

    // Smallest order whose block holds the requested size; sizes of zero and one need order 0.
    function automatic logic [ORDER_W-1:0] needed_order(input logic [SIZE_W-1:0] size);
        logic [ORDER_W-1:0] k;
        k = ORDER_W'(MAX_ORDER);
        for (int i = MAX_ORDER - 1; i >= 0; i--) begin
            if ({1'b0, size} <= (SIZE_W + 1)'(1 << i)) begin
                k = ORDER_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic too_big(input logic [SIZE_W-1:0] size);
        return {1'b0, size} > (SIZE_W + 1)'(1 << MAX_ORDER);
    endfunction

    function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] value);
        return (value > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : value;
    endfunction

endpackage

`default_nettype wire

// ===== design/bba_row.sv =====
// Block row storage: one write port and one registered read port.
`default_nettype none

module bba_row (
    input  wire logic              clk,
    input  wire bba_pkg::row_wr_t  wr,
    input  wire bba_pkg::row_rd_t  rd,
    output bba_pkg::row_entry_t    rd_data
);
    import bba_pkg::*;

    row_entry_t mem [ROW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: sequencer, result register and block row.
`default_nettype none

// The allocator keeps an address-ordered row of up to 64 buddy blocks in a single-port-write,
// single-port-read memory, and one sequencer walks that row through one read port. Every split
// adds a shift of the blocks to the right of the split block (one entry per cycle), a write of
// the halves in ST_SPLIT_LO and ST_SPLIT_HI and a fresh scan. The worst case is therefore seven
// scans and six shifts of a row of up to 64 blocks. A request for more than 64 units is answered
// without a scan. A listing reads each block in ST_LIST_RD and loads it into the result
// register in ST_LIST_LD; it waits in ST_LIST_RD while the result side stalls. After reset and
// after each total_order write the block writes the initial free block in ST_INIT before it
// takes a request. total_order is written only while the sequencer is idle; a register write
// offered in the same cycle as a request goes first, and the request waits. Values above six
// are taken as six.
module buddy_block_allocator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire bba_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output bba_pkg::rsp_item_t      rsp,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_data
);
    import bba_pkg::*;

    state_t             state_reg, state_next;
    logic [ORDER_W-1:0] total_order_reg, total_order_next;
    logic [CNT_W-1:0]   blocks_reg, blocks_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  paddr_reg, paddr_next;
    logic               found_reg, found_next;
    logic [ADDR_W-1:0]  split_idx_reg, split_idx_next;
    logic [ORDER_W-1:0] split_ord_reg, split_ord_next;
    logic               ok_reg, ok_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [ORDER_W-1:0] need_reg, need_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    rsp_item_t          rsp_reg, rsp_next;

    row_wr_t    wr;
    row_rd_t    rd;
    row_entry_t rd_data;
    logic       rsp_free;
    logic       shift_more;

    bba_row u_row (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign shift_more = idx_reg > {1'b0, split_idx_reg};

    always_comb
    begin
        state_next       = state_reg;
        total_order_next = total_order_reg;
        blocks_next      = blocks_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        paddr_next       = paddr_reg;
        found_next       = found_reg;
        split_idx_next   = split_idx_reg;
        split_ord_next   = split_ord_reg;
        ok_next          = ok_reg;
        need_next        = need_reg;
        owner_next       = owner_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        wr               = '0;
        rd               = '0;
        req_ready        = 1'b0;
        cfg_ready        = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                wr.en       = 1'b1;
                wr.addr     = '0;
                wr.data     = '{order: total_order_reg, owner: '0};
                blocks_next = CNT_W'(1);
                state_next  = ST_IDLE;
            end

            ST_IDLE:
            begin
                req_ready = !cfg_valid;
                cfg_ready = 1'b1;
                if (cfg_valid)
                begin
                    total_order_next = clamp_order(cfg_data);
                    state_next       = ST_INIT;
                end
                else if (req_valid)
                begin
                    need_next  = needed_order(req.request_size);
                    owner_next = req.owner_id;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    if (req.command == CMD_LIST)
                    begin
                        state_next = ST_LIST_RD;
                    end
                    else if (too_big(req.request_size))
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Reads run one entry ahead of the compare on the registered read data.
                pend_next = 1'b0;
                if (idx_reg < blocks_reg)
                begin
                    rd.en      = 1'b1;
                    rd.addr    = idx_reg[ADDR_W-1:0];
                    idx_next   = idx_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                    paddr_next = idx_reg[ADDR_W-1:0];
                end
                if (pend_reg)
                begin
                    if (rd_data.owner == '0 && rd_data.order == need_reg)
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = paddr_reg;
                        wr.data    = '{order: need_reg, owner: owner_reg};
                        ok_next    = 1'b1;
                        state_next = ST_REPORT;
                    end
                    else if (rd_data.owner == '0 && rd_data.order > need_reg && !found_reg)
                    begin
                        found_next     = 1'b1;
                        split_idx_next = paddr_reg;
                        split_ord_next = rd_data.order;
                    end
                end
                else if (idx_reg >= blocks_reg)
                begin
                    if (found_reg && blocks_reg != CNT_W'(ROW_DEPTH))
                    begin
                        idx_next   = blocks_reg - CNT_W'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_REPORT;
                    end
                end
            end

            ST_SHIFT:
            begin
                // Moves the blocks right of the split block up by one, highest entry first.
                pend_next = 1'b0;
                if (pend_reg)
                begin
                    wr.en   = 1'b1;
                    wr.addr = paddr_reg;
                    wr.data = rd_data;
                end
                if (shift_more)
                begin
                    rd.en      = 1'b1;
                    rd.addr    = idx_reg[ADDR_W-1:0];
                    pend_next  = 1'b1;
                    paddr_next = idx_reg[ADDR_W-1:0] + ADDR_W'(1);
                    idx_next   = idx_reg - CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_SPLIT_LO;
                end
            end

            ST_SPLIT_LO:
            begin
                wr.en      = 1'b1;
                wr.addr    = split_idx_reg;
                wr.data    = '{order: split_ord_reg - ORDER_W'(1), owner: '0};
                state_next = ST_SPLIT_HI;
            end

            ST_SPLIT_HI:
            begin
                wr.en       = 1'b1;
                wr.addr     = split_idx_reg + ADDR_W'(1);
                wr.data     = '{order: split_ord_reg - ORDER_W'(1), owner: '0};
                blocks_next = blocks_reg + CNT_W'(1);
                idx_next    = '0;
                pend_next   = 1'b0;
                found_next  = 1'b0;
                state_next  = ST_SCAN;
            end

            ST_REPORT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.result_kind = KIND_ALLOC;
                    rsp_next.status      = ok_reg ? STATUS_OK : STATUS_NO_SPACE;
                    rsp_next.block_count = blocks_reg;
                    rsp_next.block_owner = ok_reg ? owner_reg : '0;
                    rsp_next.block_order = ok_reg ? need_reg : '0;
                    rsp_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            ST_LIST_RD:
            begin
                // The read is issued only once the result register will be empty next cycle.
                if (rsp_free)
                begin
                    rd.en      = 1'b1;
                    rd.addr    = idx_reg[ADDR_W-1:0];
                    state_next = ST_LIST_LD;
                end
            end

            ST_LIST_LD:
            begin
                rsp_valid_next       = 1'b1;
                rsp_next.result_kind = KIND_BLOCK;
                rsp_next.status      = STATUS_OK;
                rsp_next.block_count = blocks_reg;
                rsp_next.block_owner = rd_data.owner;
                rsp_next.block_order = rd_data.order;
                rsp_next.last        = (idx_reg + CNT_W'(1)) == blocks_reg;
                idx_next             = idx_reg + CNT_W'(1);
                state_next           = ((idx_reg + CNT_W'(1)) == blocks_reg) ? ST_IDLE
                                                                            : ST_LIST_RD;
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            total_order_reg <= ORDER_W'(MAX_ORDER);
            blocks_reg      <= CNT_W'(1);
            idx_reg         <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            ok_reg          <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            total_order_reg <= total_order_next;
            blocks_reg      <= blocks_next;
            idx_reg         <= idx_next;
            pend_reg        <= pend_next;
            found_reg       <= found_next;
            ok_reg          <= ok_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg     <= paddr_next;
        split_idx_reg <= split_idx_next;
        split_ord_reg <= split_ord_next;
        need_reg      <= need_next;
        owner_reg     <= owner_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== design/bba_checker.sv =====
// Port-level checks of the buddy block allocator and their binding to the top level.
`default_nettype none

module bba_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_ready,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_ready,
    input  wire bba_pkg::rsp_item_t rsp,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready
);
    import bba_pkg::*;

    // A stalled result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed or dropped while stalled");

    // Every request keeps the sequencer busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken back to back");

    // A register write reinitializes the row before the next request.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !req_ready && !cfg_ready)
        else $error("request accepted during row initialization");

    // Requests are taken only in the idle window, and a register write goes first.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> cfg_ready && !cfg_valid)
        else $error("request accepted outside the idle window");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
